// ===== hw/rtl/nsd_pkg.sv =====
// Package for the normalized sequence distance block: payload structs,
// mode codes and the job record handed from accumulator to finisher.
package nsd_pkg;

   typedef enum logic [1:0] {
      MODE_BRAY   = 2'd0,
      MODE_EUCLID = 2'd1,
      MODE_CITY   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE    = 3'd0,
      REG_WEIGHT  = 3'd1,
      REG_COORD1  = 3'd2,
      REG_COORD2  = 3'd3,
      REG_COORD3  = 3'd4,
      REG_COORD4  = 3'd5
   } reg_index_type;

   // Longest sequence the sums are sized for; 48-bit sums cannot overflow below it.
   localparam int unsigned MAX_LENGTH = 4096;

   localparam int unsigned ACC_W = 48;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   typedef struct packed {
      logic [2:0] x_level;
      logic [2:0] y_level;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [15:0] distance;
      logic        zero_denominator;
   } rsp_type;

   // One finished sequence waiting for division.
   typedef struct packed {
      logic [ACC_W-1:0] num;
      logic [ACC_W-1:0] den;
      logic             euclid;
      logic             none;
   } job_type;

   typedef enum logic [1:0] {
      FIN_IDLE = 2'd0,
      FIN_DIV  = 2'd1,
      FIN_SQRT = 2'd2,
      FIN_DONE = 2'd3
   } fin_state_type;

endpackage

// ===== hw/rtl/nsd_front.sv =====
// Front end: maps levels, accumulates numerator and denominator per pair,
// and pushes a job record on the last pair. Depends on nsd_pkg.
module nsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  nsd_pkg::req_type  in_data,
   output logic              in_take,
   input  logic [1:0]        mode,
   input  logic              weighted,
   input  logic [63:0]       coords,
   output logic              job_valid,
   output nsd_pkg::job_type  job_data,
   input  logic              job_full
);
   import nsd_pkg::*;

   logic [ACC_W-1:0] num_ff, num_in, den_ff, den_in;
   logic [15:0] xv, yv, diff, span;
   logic [ACC_W-1:0] nterm, dterm;
   logic [ACC_W:0] nsum, dsum;

   function automatic logic [15:0] map_level(input logic [2:0] l, input logic w,
                                              input logic [63:0] c);
      logic [2:0] k;
      k = (l > 3'd4) ? 3'd4 : l;
      if (!w) return {13'd0, k};
      case (k)
         3'd0: return 16'd0;
         3'd1: return c[15:0];
         3'd2: return c[31:16];
         3'd3: return c[47:32];
         default: return c[63:48];
      endcase
   endfunction

   // Accept a pair only when a last pair can be queued.
   assign in_take = in_valid && !job_full;

   // Per-pair terms.
   always_comb begin
      xv = map_level(in_data.x_level, weighted, coords);
      yv = map_level(in_data.y_level, weighted, coords);
      diff = (xv > yv) ? xv - yv : yv - xv;
      span = weighted ? coords[63:48] : 16'd4;
      case (mode)
         MODE_BRAY: begin
            nterm = {32'd0, diff};
            dterm = {31'd0, {1'b0, xv} + {1'b0, yv}};
         end
         MODE_EUCLID: begin
            nterm = {16'd0, 32'(diff) * 32'(diff)};
            dterm = {16'd0, 32'(span) * 32'(span)};
         end
         MODE_CITY: begin
            nterm = {32'd0, diff};
            dterm = {32'd0, span};
         end
         default: begin
            nterm = '0;
            dterm = '0;
         end
      endcase
      nsum = {1'b0, num_ff} + {1'b0, nterm};
      dsum = {1'b0, den_ff} + {1'b0, dterm};
   end

   // Saturating sums, cleared once the last pair is queued.
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (in_take) begin
         num_in = nsum[ACC_W] ? ACC_MAX : nsum[ACC_W-1:0];
         den_in = dsum[ACC_W] ? ACC_MAX : dsum[ACC_W-1:0];
         if (in_data.last_pair) begin
            num_in = '0;
            den_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         den_ff <= '0;
      end else begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // Job record for the finisher.
   always_comb begin
      job_valid = in_take && in_data.last_pair;
      job_data.num = nsum[ACC_W] ? ACC_MAX : nsum[ACC_W-1:0];
      job_data.den = dsum[ACC_W] ? ACC_MAX : dsum[ACC_W-1:0];
      job_data.euclid = (mode == MODE_EUCLID);
      job_data.none = (mode == MODE_NONE);
   end
endmodule

// ===== hw/rtl/nsd_queue.sv =====
// Two-entry queue of job records between front end and finisher.
// Depends on nsd_pkg.
module nsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nsd_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output nsd_pkg::job_type  head
);
   import nsd_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = mem_ff[rp_ff];

   // Pointer and count update.
   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/nsd_finish.sv =====
// Finisher: bit-serial fractional division, optional bit-serial square
// root, saturation, and a result register. Depends on nsd_pkg.
module nsd_finish #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  nsd_pkg::job_type  job,
   output logic              job_pop,
   output logic              out_valid,
   output nsd_pkg::rsp_type  out_data,
   input  logic              out_stall
);
   import nsd_pkg::*;

   localparam int unsigned QW = 2 * FRAC_BITS;
   localparam int unsigned CW = $clog2(QW + 1);
   localparam logic [FRAC_BITS-1:0] SATV = {FRAC_BITS{1'b1}};

   fin_state_type state_ff, state_in;
   logic [ACC_W:0]   rem_ff, rem_in;
   logic [ACC_W-1:0] den_ff, den_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             euc_ff, euc_in;
   logic [QW-1:0]    sx_ff, sx_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [FRAC_BITS-1:0] res_ff, res_in;
   logic             zero_ff, zero_in;
   logic             ov_ff, ov_in;
   logic [ACC_W:0]   shifted;
   logic [QW-1:0]    strial;
   logic             start, imm;
   logic [FRAC_BITS-1:0] imm_res;
   logic             imm_zero;

   // The job is finished at once when trivial.
   always_comb begin
      imm_zero = job.none || (job.den == '0);
      imm = imm_zero || (job.num >= job.den);
      imm_res = imm_zero ? '0 : SATV;
      start = (state_ff == FIN_IDLE) && job_ready && !(ov_ff && out_stall);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FIN_IDLE: if (start && !imm) state_in = FIN_DIV;
         FIN_DIV:  if (cnt_ff == CW'(1)) state_in = euc_ff ? FIN_SQRT : FIN_DONE;
         FIN_SQRT: if (sb_ff == QW'(1)) state_in = FIN_DONE;
         FIN_DONE: if (!(ov_ff && out_stall)) state_in = FIN_IDLE;
         default:  state_in = FIN_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      euc_in = euc_ff;
      sx_in = sx_ff;
      sr_in = sr_ff;
      sb_in = sb_ff;
      res_in = res_ff;
      zero_in = zero_ff;
      ov_in = ov_ff && out_stall;
      job_pop = start;
      shifted = {rem_ff[ACC_W-1:0], 1'b0};
      strial = sr_ff + sb_ff;
      unique case (state_ff)
         FIN_IDLE: begin
            if (start) begin
               rem_in = {1'b0, job.num};
               den_in = job.den;
               q_in = '0;
               euc_in = job.euclid;
               cnt_in = job.euclid ? CW'(QW) : CW'(FRAC_BITS);
               if (imm) begin
                  res_in = imm_res;
                  zero_in = imm_zero;
                  ov_in = 1'b1;
               end
            end
         end
         FIN_DIV: begin
            if (shifted >= {1'b0, den_ff}) begin
               rem_in = shifted - {1'b0, den_ff};
               q_in = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               q_in = {q_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            sx_in = euc_ff ? {q_in} : '0;
            sr_in = '0;
            sb_in = {2'b01, {(QW-2){1'b0}}};
         end
         FIN_SQRT: begin
            if (sx_ff >= strial) begin
               sx_in = sx_ff - strial;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
         end
         FIN_DONE: begin
            if (!(ov_ff && out_stall)) begin
               res_in = euc_ff ? sr_ff[FRAC_BITS-1:0] : q_ff[FRAC_BITS-1:0];
               zero_in = 1'b0;
               ov_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIN_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      euc_ff <= euc_in;
      sx_ff <= sx_in;
      sr_ff <= sr_in;
      sb_ff <= sb_in;
      res_ff <= res_in;
      zero_ff <= zero_in;
   end

   // Output register; results above 16 bits clamp to all ones.
   always_comb begin
      out_valid = ov_ff;
      if (FRAC_BITS > 16) begin
         out_data.distance = (res_ff > FRAC_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(res_ff);
      end else begin
         out_data.distance = 16'(res_ff);
      end
      out_data.zero_denominator = zero_ff;
   end
endmodule

// ===== hw/rtl/normalized_sequence_distance.sv =====
// Top level of the normalized sequence distance block.
// Depends on nsd_pkg, nsd_front, nsd_queue and nsd_finish.
//
// Usage: each request carries one aligned pair of levels (0 to 4) and a
// last-pair flag. Requests are taken on the req_ channel whenever req_valid
// is high and req_stall is low; the accumulator takes one request per cycle.
// On the last pair a job goes into a two-entry queue and the finisher turns
// it into one rsp_ item: distance in Q0.DIST_FRAC_BITS and a zero-denominator
// flag. The finisher runs a bit-serial divider, one quotient bit a cycle:
// DIST_FRAC_BITS quotient bits for Bray-Curtis and cityblock, 2*DIST_FRAC_BITS
// bits plus DIST_FRAC_BITS root steps for Euclidean; a zero denominator or
// saturating ratio is finished at once. Requests stall only when the queue is
// full of unfinished sequences. A stalled response holds in the output
// register; the finisher waits. Reset clears the sums, queue pointers, finisher
// state and registers. The user must write registers on the csr_ channel only
// while the block is idle; the block itself does not enforce this.
module normalized_sequence_distance #(
   parameter int unsigned DIST_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nsd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nsd_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import nsd_pkg::*;

   logic [1:0]  mode_ff;
   logic        weight_ff;
   logic [63:0] coords_ff;
   logic        take, job_valid, job_full, job_pop, job_ne;
   job_type     job_in, job_head;

   // Register file.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         weight_ff <= 1'b0;
         coords_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:   mode_ff <= csr_data[1:0];
            REG_WEIGHT: weight_ff <= csr_data[0];
            REG_COORD1: coords_ff[15:0] <= csr_data;
            REG_COORD2: coords_ff[31:16] <= csr_data;
            REG_COORD3: coords_ff[47:32] <= csr_data;
            REG_COORD4: coords_ff[63:48] <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = !take;

   nsd_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_data(req_data), .in_take(take),
      .mode(mode_ff), .weighted(weight_ff), .coords(coords_ff),
      .job_valid, .job_data(job_in), .job_full
   );

   nsd_queue u_queue (
      .clock, .reset,
      .push(job_valid), .push_data(job_in), .full(job_full),
      .pop(job_pop), .not_empty(job_ne), .head(job_head)
   );

   nsd_finish #(.FRAC_BITS(DIST_FRAC_BITS)) u_finish (
      .clock, .reset,
      .job_ready(job_ne), .job(job_head), .job_pop,
      .out_valid(rsp_valid), .out_data(rsp_data), .out_stall(rsp_stall)
   );

   // A flagged zero denominator always comes with distance zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |-> rsp_data.distance == 16'd0)
      else $error("zero denominator with nonzero distance");
   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
   // Requests are refused only when the job queue is full.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> job_full)
      else $error("request stalled without a full queue");
endmodule

// ===== verif/normalized_sequence_distance_test.sv =====
// Self-checking testbench for the normalized sequence distance block.
// Depends on nsd_pkg and normalized_sequence_distance, which needs nsd_front, nsd_queue and nsd_finish.
module normalized_sequence_distance_test;
   timeunit 1ns;
   timeprecision 1ps;
   import nsd_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int DRAIN_CYCLES = 90;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [47:0] SUM_MAX = {48{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   normalized_sequence_distance dut (.*);

   // Predictor state: registers and running sums as the block should hold them.
   mode_type pred_mode = MODE_BRAY;
   logic pred_weighted = 1'b0;
   logic [15:0] pred_coord [4] = '{default: '0};
   logic [47:0] pred_num = '0;
   logic [47:0] pred_den = '0;
   rsp_type expected_rsp [$];

   int mismatches = 0;
   int pair_count = 0;
   int csr_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_requested = 0;
   int holds_done = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [47:0] level_value(logic [2:0] lvl);
      logic [2:0] l;
      l = (lvl > 3'd4) ? 3'd4 : lvl;
      if (!pred_weighted) return 48'(l);
      if (l == 3'd0) return '0;
      return 48'(pred_coord[l - 1]);
   endfunction

   function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? SUM_MAX : s[47:0];
   endfunction

   // Long division of n by d giving bits fraction bits, n below d.
   function automatic logic [63:0] fraction_bits(logic [63:0] n, logic [63:0] d, int bits);
      logic [63:0] rem, q;
      rem = n;
      q = '0;
      for (int i = 0; i < bits; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Fold one accepted pair into the sums; a last pair yields the expected distance.
   function automatic void accumulate_pair(req_type p);
      logic [47:0] x, y, diff, span;
      logic [63:0] dist_val;
      rsp_type r;
      x = level_value(p.x_level);
      y = level_value(p.y_level);
      diff = (x > y) ? x - y : y - x;
      span = pred_weighted ? 48'(pred_coord[3]) : 48'd4;
      case (pred_mode)
         MODE_BRAY: begin
            pred_num = add_sat(pred_num, diff);
            pred_den = add_sat(pred_den, x + y);
         end
         MODE_EUCLID: begin
            pred_num = add_sat(pred_num, diff * diff);
            pred_den = add_sat(pred_den, span * span);
         end
         MODE_CITY: begin
            pred_num = add_sat(pred_num, diff);
            pred_den = add_sat(pred_den, span);
         end
         default: ;
      endcase
      if (!p.last_pair) return;
      dist_val = '0;
      r.zero_denominator = 1'b0;
      if (pred_mode == MODE_NONE || pred_den == 0) begin
         r.zero_denominator = 1'b1;
      end else if (pred_num >= pred_den) begin
         dist_val = 64'hFFFF;
      end else if (pred_mode == MODE_EUCLID) begin
         dist_val = int_sqrt(fraction_bits(pred_num, pred_den, 2 * FRAC_BITS));
      end else begin
         dist_val = fraction_bits(pred_num, pred_den, FRAC_BITS);
      end
      if (dist_val > 64'hFFFF) dist_val = 64'hFFFF;
      r.distance = dist_val[15:0];
      expected_rsp = {expected_rsp, r};
      pred_num = '0;
      pred_den = '0;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [15:0] val);
      case (reg_index_type'(idx))
         REG_MODE:   pred_mode = mode_type'(val[1:0]);
         REG_WEIGHT: pred_weighted = val[0];
         REG_COORD1: pred_coord[0] = val;
         REG_COORD2: pred_coord[1] = val;
         REG_COORD3: pred_coord[2] = val;
         REG_COORD4: pred_coord[3] = val;
         default: ;
      endcase
   endfunction

   // Watch accepted requests and register writes at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         accumulate_pair(req_data);
         pair_count <= pair_count + 1;
      end
      if (!reset && csr_valid && csr_ready) begin
         apply_register(csr_index, csr_data);
         csr_count <= csr_count + 1;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: distance %0d zero %0b",
                        rsp_data.distance, rsp_data.zero_denominator);
         end else begin
            want = expected_rsp.pop_front();
            if (want.distance !== rsp_data.distance ||
                want.zero_denominator !== rsp_data.zero_denominator) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected distance %0d zero %0b, got %0d %0b",
                           want.distance, want.zero_denominator,
                           rsp_data.distance, rsp_data.zero_denominator);
            end
         end
      end
   end

   // Receiver stall: random stalls, plus long hold-offs on request.
   always @(negedge clock) begin
      int hold_left;
      if (holds_done < holds_requested) begin
         holds_done = holds_done + 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("normalized_sequence_distance_test: errors");
         $finish;
      end
   end

   // Offer one pair and wait until it is accepted.
   task automatic send_pair(logic [2:0] x, logic [2:0] y, logic last);
      int seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data = '{x_level: x, y_level: y, last_pair: last};
      req_valid = 1'b1;
      seen = pair_count;
      while (pair_count == seen) @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_register(reg_index_type idx, logic [15:0] val);
      int seen;
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      seen = csr_count;
      while (csr_count == seen) @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Wait for every expected result, then let the finisher settle.
   task automatic wait_idle();
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(mode_type m, logic w, logic [15:0] c1, logic [15:0] c2,
                            logic [15:0] c3, logic [15:0] c4);
      wait_idle();
      write_register(REG_MODE, 16'(m));
      write_register(REG_WEIGHT, 16'(w));
      write_register(REG_COORD1, c1);
      write_register(REG_COORD2, c2);
      write_register(REG_COORD3, c3);
      write_register(REG_COORD4, c4);
   endtask

   function automatic logic [2:0] random_level();
      return ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
   endfunction

   function automatic logic [15:0] random_coord();
      case ($urandom_range(3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One sequence of random pairs, usually short.
   task automatic send_sequence(int len);
      for (int i = 0; i < len; i++)
         send_pair(random_level(), random_level(), i == len - 1);
   endtask

   // Extremes of the levels, each mode, zero denominator and saturation.
   task automatic test_directed();
      send_pair(3'd0, 3'd4, 1'b0);
      send_pair(3'd4, 3'd0, 1'b0);
      send_pair(3'd7, 3'd5, 1'b1);
      send_pair(3'd0, 3'd0, 1'b1);
      send_pair(3'd6, 3'd1, 1'b1);
      configure(MODE_EUCLID, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pair(3'd4, 3'd0, 1'b1);
      send_pair(3'd1, 3'd2, 1'b0);
      send_pair(3'd3, 3'd3, 1'b1);
      configure(MODE_CITY, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pair(3'd2, 3'd4, 1'b1);
      configure(MODE_CITY, 1'b1, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
      send_pair(3'd1, 3'd4, 1'b0);
      send_pair(3'd7, 3'd0, 1'b1);
      // Non-monotone coordinates push the ratio past one.
      configure(MODE_CITY, 1'b1, 16'hFFFF, 16'h0001, 16'h8000, 16'h0001);
      send_pair(3'd1, 3'd0, 1'b1);
      configure(MODE_EUCLID, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pair(3'd0, 3'd4, 1'b0);
      send_pair(3'd2, 3'd2, 1'b1);
      configure(MODE_NONE, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pair(3'd4, 3'd1, 1'b0);
      send_pair(3'd3, 3'd0, 1'b1);
   endtask

   // Random sequences under several random settings.
   task automatic test_random_settings(int settings, int pairs_each);
      mode_type m;
      int sent;
      int len;
      for (int s = 0; s < settings; s++) begin
         m = ($urandom_range(11) == 0) ? MODE_NONE : mode_type'($urandom_range(2));
         configure(m, 1'($urandom), random_coord(), random_coord(), random_coord(),
                   random_coord());
         sent = 0;
         while (sent < pairs_each) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            send_sequence(len);
            sent += len;
         end
      end
   endtask

   // Hold the receiver off while one-pair sequences keep coming.
   task automatic test_backpressure();
      configure(MODE_EUCLID, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_requested = holds_requested + 1;
      for (int i = 0; i < 12; i++)
         send_pair(random_level(), random_level(), 1'b1);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed();
      send_idle_pct = 20;
      recv_idle_pct = 68;
      test_random_settings(6, 50);
      send_idle_pct = 68;
      recv_idle_pct = 20;
      test_random_settings(6, 50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings(6, 50);
      test_backpressure();
      wait_idle();
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("normalized_sequence_distance_test: clean");
      else
         $display("normalized_sequence_distance_test: errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/nsd_pkg.sv
hw/rtl/nsd_front.sv
hw/rtl/nsd_queue.sv
hw/rtl/nsd_finish.sv
hw/rtl/normalized_sequence_distance.sv
verif/normalized_sequence_distance_test.sv
